FILE: rtl/core/tmc_pkg.sv
// Shared types, codes and helpers for the trimmed-mean line sensor classifier.
// No dependencies; the top level, tmc_rank, tmc_div and the testbench import this package.
`default_nettype none

package tmc_pkg;

  localparam int DATA_W      = 12;
  localparam int IDX_W       = 3;
  localparam int CFG_IDX_W   = 2;
  localparam logic [DATA_W-1:0] MAXV = 12'hFFF;

  // Default build parameters.
  localparam int SENSORS_DEF = 8;
  localparam int WINDOW_DEF  = 8;
  localparam int TRIM_DEF    = 2;

  // Input action codes.
  typedef logic [1:0] action_t;
  localparam action_t ACT_SAMPLE = 2'd0;
  localparam action_t ACT_BLACK  = 2'd1;
  localparam action_t ACT_WHITE  = 2'd2;

  // Line classification codes.
  typedef logic [1:0] line_t;
  localparam line_t LS_UNDEF = 2'd0;
  localparam line_t LS_BLACK = 2'd1;
  localparam line_t LS_WHITE = 2'd2;

  // Learned polarity codes.
  typedef logic [1:0] pol_t;
  localparam pol_t POL_NONE     = 2'd0;
  localparam pol_t POL_BLACK_HI = 2'd1;
  localparam pol_t POL_WHITE_HI = 2'd2;

  // Configuration register indexes.
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_MODE      = 2'd0;
  localparam cfg_idx_t REG_BLACK_OFS = 2'd1;
  localparam cfg_idx_t REG_WHITE_OFS = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RANK,
    S_DIV,
    S_CLS1,
    S_CLS2,
    S_CLS3,
    S_OUT
  } state_t;

  function automatic logic [DATA_W-1:0] sat_add(input logic [DATA_W-1:0] a,
                                                input logic [DATA_W-1:0] b);
    logic [DATA_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[DATA_W] ? MAXV : s[DATA_W-1:0];
  endfunction

  function automatic logic [DATA_W-1:0] sat_sub(input logic [DATA_W-1:0] a,
                                                input logic [DATA_W-1:0] b);
    return (a > b) ? (a - b) : '0;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/trimmed_mean_line_sensor_classifier.sv
// Top level: per-sensor sample windows, trimmed mean and line classification.
// Depends on tmc_pkg, tmc_ram, tmc_rank and tmc_div.
//
//   channel  | signals                                         | dir
//   ---------+-------------------------------------------------+-----
//   config   | cfg_we, cfg_index, cfg_data                     | in
//   input    | in_valid/in_ready, action, sensor_index,        | in
//            | sample_value                                    |
//   result   | out_valid/out_ready, result_sensor,             | out
//            | filtered_value, line_state                      |
//
// A threshold write, an ignored item or a sample that does not fill its
//   window leaves the sequencer in S_IDLE, so in_ready stays high for the next item.
// A sample that fills a window holds in_ready low until the output load:
//   the single comparator in tmc_rank visits every window pair (reads on
//   the two RAM ports, then the read and accumulate registers), tmc_div
//   does one reciprocal multiply, then three classify steps and the output
//   load, which waits while an earlier result is still untaken.
// Reset (synchronous) clears fill counts, thresholds, polarity, configuration
//   registers, out_valid and the sequencer; window RAM contents are not cleared, none needed.
// A stalled result sits in the output register; the sequencer only waits in
//   S_OUT when a second result is ready before the first is transferred.
`default_nettype none

module trimmed_mean_line_sensor_classifier #(
  parameter int SENSORS = tmc_pkg::SENSORS_DEF,
  parameter int WINDOW  = tmc_pkg::WINDOW_DEF,
  parameter int TRIM    = tmc_pkg::TRIM_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // configuration writes
  input  wire logic                           cfg_we,
  input  wire logic [tmc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tmc_pkg::DATA_W-1:0]     cfg_data,
  // input items
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [1:0]                     action,
  input  wire logic [tmc_pkg::IDX_W-1:0]      sensor_index,
  input  wire logic [tmc_pkg::DATA_W-1:0]     sample_value,
  // result items
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic      [tmc_pkg::IDX_W-1:0]      result_sensor,
  output logic      [tmc_pkg::DATA_W-1:0]     filtered_value,
  output logic      [1:0]                     line_state
);
  import tmc_pkg::*;

  // Effective trim leaves at least one sample averaged.
  localparam int TRIM_EFF = (2 * TRIM >= WINDOW) ? (WINDOW - 1) / 2 : TRIM;
  localparam int KEEP     = WINDOW - 2 * TRIM_EFF;
  localparam int SEN_W    = (SENSORS > 1) ? $clog2(SENSORS) : 1;
  localparam int FILL_W   = $clog2(WINDOW);
  localparam int ADDR_W   = SEN_W + FILL_W;
  localparam int SUM_W    = DATA_W + FILL_W;
  localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(WINDOW - 1);

  state_t state, state_next;

  // per-sensor state
  logic [FILL_W-1:0] fill    [SENSORS];
  logic [DATA_W-1:0] blk_thr [SENSORS];
  logic [DATA_W-1:0] wht_thr [SENSORS];
  pol_t              pol     [SENSORS];

  // configuration registers
  logic              cls_mode;
  logic [DATA_W-1:0] blk_ofs, wht_ofs;

  // decode of the item at the port
  logic [3:0]       idx_ext;
  logic [SEN_W-1:0] in_sidx;
  logic             in_range;
  logic             in_fire;
  logic             smp_fire;
  logic             win_done;

  // current window
  logic [IDX_W-1:0]  cur_tag;
  logic [3:0]        cur_ext;
  logic [SEN_W-1:0]  cur_sidx;
  logic [DATA_W-1:0] cur_blk, cur_wht;
  pol_t              cur_pol;

  // datapath registers
  logic [DATA_W-1:0] mean_q, mid_q, hi_q, lo_q;
  line_t             cls_state;
  line_t             line_q;

  // engines and RAM
  logic [FILL_W-1:0] slot_a, slot_b;
  logic [DATA_W-1:0] rd_a, rd_b;
  logic              rank_done, div_done, div_start;
  logic [SUM_W-1:0]  rank_sum;
  logic [DATA_W-1:0] div_q;
  logic              out_load;

  assign idx_ext  = {1'b0, sensor_index};
  assign in_sidx  = idx_ext[SEN_W-1:0];
  assign in_range = ({2'b00, sensor_index} < 5'(SENSORS));
  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign smp_fire = in_fire && in_range && (action == ACT_SAMPLE);
  assign win_done = smp_fire && (fill[in_sidx] == FILL_LAST);

  assign cur_ext  = {1'b0, cur_tag};
  assign cur_sidx = cur_ext[SEN_W-1:0];
  assign cur_blk  = blk_thr[cur_sidx];
  assign cur_wht  = wht_thr[cur_sidx];
  assign cur_pol  = pol[cur_sidx];

  // ---------------------------------------------------------------------
  // Window storage: address = {sensor, slot}
  // ---------------------------------------------------------------------
  tmc_ram #(
    .WIDTH (DATA_W),
    .DEPTH (1 << ADDR_W)
  ) u_win (
    .clk     (clk),
    .we      (smp_fire),
    .waddr   ({in_sidx, fill[in_sidx]}),
    .wdata   (sample_value),
    .raddr_a ({cur_sidx, slot_a}),
    .rdata_a (rd_a),
    .raddr_b ({cur_sidx, slot_b}),
    .rdata_b (rd_b)
  );

  tmc_rank #(
    .WINDOW  (WINDOW),
    .RANK_LO (TRIM_EFF),
    .RANK_HI (WINDOW - TRIM_EFF)
  ) u_rank (
    .clk    (clk),
    .rst    (rst),
    .start  (win_done),
    .slot_a (slot_a),
    .slot_b (slot_b),
    .rd_a   (rd_a),
    .rd_b   (rd_b),
    .done   (rank_done),
    .sum    (rank_sum)
  );

  assign div_start = (state == S_RANK) && rank_done;

  tmc_div #(
    .SUM_W (SUM_W),
    .KEEP  (KEEP)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (rank_sum),
    .done     (div_done),
    .quotient (div_q)
  );

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign out_load = (state == S_OUT) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (win_done) begin
          state_next = S_RANK;
        end
      end
      S_RANK: begin
        if (rank_done) begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_next = S_CLS1;
        end
      end
      S_CLS1:  state_next = S_CLS2;
      S_CLS2:  state_next = S_CLS3;
      S_CLS3:  state_next = S_OUT;
      S_OUT: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------
  // Per-sensor state and configuration
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < SENSORS; s++) begin
        fill[s]    <= '0;
        blk_thr[s] <= '0;
        wht_thr[s] <= '0;
        pol[s]     <= POL_NONE;
      end
      cls_mode <= 1'b0;
      blk_ofs  <= '0;
      wht_ofs  <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MODE:      cls_mode <= cfg_data[0];
          REG_BLACK_OFS: blk_ofs  <= cfg_data;
          REG_WHITE_OFS: wht_ofs  <= cfg_data;
          default:       ;
        endcase
      end
      if (in_fire && in_range) begin
        case (action)
          ACT_SAMPLE: begin
            fill[in_sidx] <= win_done ? '0 : fill[in_sidx] + 1'b1;
          end
          ACT_BLACK: begin
            blk_thr[in_sidx] <= sample_value;
            if (sample_value > wht_thr[in_sidx]) begin
              pol[in_sidx] <= POL_BLACK_HI;
            end else if (sample_value < wht_thr[in_sidx]) begin
              pol[in_sidx] <= POL_WHITE_HI;
            end
          end
          ACT_WHITE: begin
            wht_thr[in_sidx] <= sample_value;
            if (blk_thr[in_sidx] > sample_value) begin
              pol[in_sidx] <= POL_BLACK_HI;
            end else if (blk_thr[in_sidx] < sample_value) begin
              pol[in_sidx] <= POL_WHITE_HI;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------
  // Classification datapath
  // CLS1: midpoint. CLS2: band limits (lo_q is the black limit in direct
  // mode, hi_q the white limit). CLS3: final compare.
  // ---------------------------------------------------------------------
  always_comb begin
    cls_state = LS_UNDEF;
    if (cls_mode) begin
      if (mean_q >= lo_q) begin
        cls_state = LS_BLACK;
      end else if (mean_q <= hi_q) begin
        cls_state = LS_WHITE;
      end
    end else begin
      if (mean_q > hi_q) begin
        if (cur_pol == POL_BLACK_HI) begin
          cls_state = LS_BLACK;
        end else if (cur_pol == POL_WHITE_HI) begin
          cls_state = LS_WHITE;
        end
      end else if (mean_q < lo_q) begin
        if (cur_pol == POL_BLACK_HI) begin
          cls_state = LS_WHITE;
        end else if (cur_pol == POL_WHITE_HI) begin
          cls_state = LS_BLACK;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (win_done) begin
      cur_tag <= sensor_index;
    end
    if (div_done) begin
      mean_q <= div_q;
    end
    if (state == S_CLS1) begin
      mid_q <= DATA_W'(({1'b0, cur_blk} + {1'b0, cur_wht}) >> 1);
    end
    if (state == S_CLS2) begin
      if (cls_mode) begin
        lo_q <= sat_sub(cur_blk, blk_ofs);
        hi_q <= sat_add(cur_wht, wht_ofs);
      end else begin
        lo_q <= sat_sub(mid_q, blk_ofs);
        hi_q <= sat_add(mid_q, wht_ofs);
      end
    end
    // staged here, shown only through the output register
    if (state == S_CLS3) begin
      line_q <= cls_state;
    end
  end

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result_sensor  <= cur_tag;
      filtered_value <= mean_q;
      line_state     <= line_q;
    end
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_rank_in_state: assert property (@(posedge clk) disable iff (rst)
    rank_done |-> state == S_RANK)
    else $error("rank engine finished outside the rank phase");

  a_div_in_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider finished outside the divide phase");

  a_window_starts: assert property (@(posedge clk) disable iff (rst)
    win_done |=> (state == S_RANK) && !in_ready)
    else $error("full window did not start the rank phase");

  a_result_waits: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) && out_valid && !out_ready |=> state == S_OUT)
    else $error("new result dropped while output register was occupied");

endmodule

`default_nettype wire

FILE: rtl/core/tmc_ram.sv
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
`default_nettype none

module tmc_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic      [WIDTH-1:0]         rdata_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

FILE: rtl/core/tmc_rank.sv
// Rank-and-sum engine: one comparator swept over all window pairs.
// Sums the entries whose sorted rank is inside the kept band. Uses tmc_pkg.
`default_nettype none

module tmc_rank #(
  parameter int WINDOW  = tmc_pkg::WINDOW_DEF,
  parameter int RANK_LO = 2,
  parameter int RANK_HI = 6
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst,
  input  wire logic                                     start,
  output logic      [$clog2(WINDOW)-1:0]                slot_a,
  output logic      [$clog2(WINDOW)-1:0]                slot_b,
  input  wire logic [tmc_pkg::DATA_W-1:0]               rd_a,
  input  wire logic [tmc_pkg::DATA_W-1:0]               rd_b,
  output logic                                          done,
  output logic      [tmc_pkg::DATA_W+$clog2(WINDOW)-1:0] sum
);
  import tmc_pkg::*;

  localparam int SW    = $clog2(WINDOW);
  localparam int SUM_W = DATA_W + SW;
  localparam logic [SW-1:0] LAST = SW'(WINDOW - 1);

  logic          issuing;
  logic [SW-1:0] i_q, j_q;
  logic          pv, plast, pend;
  logic [SW-1:0] pi, pj;
  logic [SW-1:0] rank;
  logic          lt;
  logic [SW-1:0] rank_sum;
  logic          in_band;

  assign slot_a = i_q;
  assign slot_b = j_q;

  // rank = count of smaller entries plus equal ones at a lower slot
  assign lt       = (rd_b < rd_a) || ((rd_b == rd_a) && (pj < pi));
  assign rank_sum = rank + SW'(lt);
  assign in_band  = ({1'b0, rank_sum} >= (SW+1)'(RANK_LO)) &&
                    ({1'b0, rank_sum} <  (SW+1)'(RANK_HI));

  always_ff @(posedge clk) begin
    if (rst) begin
      issuing <= 1'b0;
      pv      <= 1'b0;
      done    <= 1'b0;
      i_q     <= '0;
      j_q     <= '0;
      rank    <= '0;
    end else begin
      done <= pv && pend;
      if (start) begin
        issuing <= 1'b1;
        i_q     <= '0;
        j_q     <= '0;
        rank    <= '0;
        sum     <= '0;
        pv      <= 1'b0;
      end else begin
        pv    <= issuing;
        pi    <= i_q;
        pj    <= j_q;
        plast <= (j_q == LAST);
        pend  <= (j_q == LAST) && (i_q == LAST);
        if (issuing) begin
          if (j_q == LAST) begin
            j_q <= '0;
            i_q <= i_q + 1'b1;
            if (i_q == LAST) begin
              issuing <= 1'b0;
            end
          end else begin
            j_q <= j_q + 1'b1;
          end
        end
        if (pv) begin
          if (plast) begin
            rank <= '0;
            if (in_band) begin
              sum <= sum + SUM_W'(rd_a);
            end
          end else begin
            rank <= rank_sum;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/tmc_div.sv
// Divider by a build-time constant: one reciprocal multiply, result registered in the cycle after start.
// Uses tmc_pkg.
`default_nettype none

module tmc_div #(
  parameter int SUM_W = 15,
  parameter int KEEP  = 4
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [SUM_W-1:0]            dividend,
  output logic                             done,
  output logic      [tmc_pkg::DATA_W-1:0]  quotient
);
  import tmc_pkg::*;

  // floor(n / KEEP) == (n * MULT) >> SHIFT for every SUM_W-bit n,
  // with MULT = ceil(2^SHIFT / KEEP) and SHIFT = SUM_W + clog2(KEEP).
  localparam int     KL    = $clog2(KEEP);
  localparam int     SHIFT = SUM_W + KL;
  localparam longint MULT  = ((longint'(1) << SHIFT) + longint'(KEEP) - 1) / longint'(KEEP);
  localparam int     MW    = SUM_W + 1;
  localparam int     PW    = SUM_W + MW;

  logic [PW-1:0] prod_q;

  assign quotient = prod_q[SHIFT +: DATA_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= start;
      if (start) begin
        prod_q <= PW'(dividend) * PW'(MULT);
      end
    end
  end

endmodule

`default_nettype wire

FILE: verif/tb_trimmed_mean_line_sensor_classifier.sv
// Testbench for the trimmed-mean line sensor classifier: directed and random items,
// with per-sensor window, threshold and polarity tracking in a scoreboard class.
// Depends on tmc_pkg and trimmed_mean_line_sensor_classifier.
module tb_trimmed_mean_line_sensor_classifier;
  timeunit 1ns;
  timeprecision 1ps;

  import tmc_pkg::*;

  localparam int NSENS  = SENSORS_DEF;
  localparam int WIN    = WINDOW_DEF;
  localparam int TRIM_N = TRIM_DEF;

  // Codes the package leaves unnamed.
  localparam action_t  ACT_UNUSED = 2'd3;
  localparam cfg_idx_t REG_NONE   = 2'd3;

  // Idle time before a register write: covers a window completion in progress.
  localparam int SETTLE_CYCLES = 120;
  localparam int PHASE_ITEMS   = 54;
  localparam int MAX_PHASES    = 7;
  // Timeout in nanoseconds; the slowest legal run stays well under it.
  localparam longint TIMEOUT_NS = 64'd10_000_000;

  typedef struct packed {
    logic [IDX_W-1:0]  sensor;
    logic [DATA_W-1:0] mean;
    line_t             state;
  } line_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0]    cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [1:0]           action = '0;
  logic [IDX_W-1:0]     sensor_index = '0;
  logic [DATA_W-1:0]    sample_value = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [IDX_W-1:0]     result_sensor;
  logic [DATA_W-1:0]    filtered_value;
  logic [1:0]           line_state;

  trimmed_mean_line_sensor_classifier #(
    .SENSORS(NSENS),
    .WINDOW (WIN),
    .TRIM   (TRIM_N)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .action        (action),
    .sensor_index  (sensor_index),
    .sample_value  (sample_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .result_sensor (result_sensor),
    .filtered_value(filtered_value),
    .line_state    (line_state)
  );

  // Tracks windows, thresholds and polarity per sensor, and holds the
  // classified means still owed by the block, oldest first.
  class line_result_tracker;
    logic [DATA_W-1:0] window_mem [NSENS][WIN];
    int                fill [NSENS];
    int                black_thr [NSENS];
    int                white_thr [NSENS];
    pol_t              pol [NSENS];
    bit                mode_direct;
    int                black_ofs;
    int                white_ofs;
    line_result_t      due_q [$];
    int                failures;

    function new();
      foreach (window_mem[s, i]) window_mem[s][i] = '0;
      foreach (fill[s]) begin
        fill[s]      = 0;
        black_thr[s] = 0;
        white_thr[s] = 0;
        pol[s]       = POL_NONE;
      end
      mode_direct = 1'b0;
      black_ofs   = 0;
      white_ofs   = 0;
      failures    = 0;
    endfunction

    function int pending();
      return due_q.size();
    endfunction

    function void set_reg(cfg_idx_t idx, logic [DATA_W-1:0] d);
      case (idx)
        REG_MODE:      mode_direct = d[0];
        REG_BLACK_OFS: black_ofs = int'(d);
        REG_WHITE_OFS: white_ofs = int'(d);
        default: ;
      endcase
    endfunction

    function int clip_add(int a, int b);
      return (a + b > 4095) ? 4095 : a + b;
    endfunction

    function int clip_sub(int a, int b);
      return (a > b) ? a - b : 0;
    endfunction

    // Equal thresholds leave the learned polarity alone.
    function void update_pol(int s);
      if (black_thr[s] > white_thr[s]) pol[s] = POL_BLACK_HI;
      else if (black_thr[s] < white_thr[s]) pol[s] = POL_WHITE_HI;
    endfunction

    function logic [DATA_W-1:0] window_mean(int s);
      int                sorted [WIN];
      int                key;
      int                j;
      int                cut;
      int                kept;
      int                total;
      logic [DATA_W-1:0] m;
      foreach (sorted[i]) sorted[i] = int'(window_mem[s][i]);
      for (int i = 1; i < WIN; i++) begin
        key = sorted[i];
        j   = i;
        while (j > 0 && sorted[j-1] > key) begin
          sorted[j] = sorted[j-1];
          j--;
        end
        sorted[j] = key;
      end
      // Trim too large for the window: keep at least one sample.
      cut   = (2 * TRIM_N >= WIN) ? (WIN - 1) / 2 : TRIM_N;
      kept  = WIN - 2 * cut;
      total = 0;
      for (int i = cut; i < cut + kept; i++) total += sorted[i];
      m = DATA_W'(total / kept);
      return m;
    endfunction

    function line_t classify_mean(int s, int v);
      int mid;
      int hi;
      int lo;
      if (mode_direct) begin
        if (v >= clip_sub(black_thr[s], black_ofs)) return LS_BLACK;
        if (v <= clip_add(white_thr[s], white_ofs)) return LS_WHITE;
        return LS_UNDEF;
      end
      mid = (black_thr[s] + white_thr[s]) >> 1;
      hi  = clip_add(mid, white_ofs);
      lo  = clip_sub(mid, black_ofs);
      if (v > hi)
        return (pol[s] == POL_BLACK_HI) ? LS_BLACK : (pol[s] == POL_WHITE_HI) ? LS_WHITE : LS_UNDEF;
      if (v < lo)
        return (pol[s] == POL_BLACK_HI) ? LS_WHITE : (pol[s] == POL_WHITE_HI) ? LS_BLACK : LS_UNDEF;
      return LS_UNDEF;
    endfunction

    function void note_input(action_t act, logic [IDX_W-1:0] sidx, logic [DATA_W-1:0] val);
      int           s;
      line_result_t r;
      s = int'(sidx);
      if (s >= NSENS) return;
      case (act)
        ACT_BLACK: begin
          black_thr[s] = int'(val);
          update_pol(s);
        end
        ACT_WHITE: begin
          white_thr[s] = int'(val);
          update_pol(s);
        end
        ACT_SAMPLE: begin
          if (fill[s] >= WIN) fill[s] = 0;
          window_mem[s][fill[s]] = val;
          fill[s]++;
          if (fill[s] == WIN) begin
            fill[s]  = 0;
            r.sensor = sidx;
            r.mean   = window_mean(s);
            r.state  = classify_mean(s, int'(r.mean));
            due_q.push_back(r);
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [IDX_W-1:0] sid, logic [DATA_W-1:0] mean, line_t st);
      line_result_t want;
      if (due_q.size() == 0) begin
        failures++;
        $error("unexpected result: sensor %0d, value %0d, state %0d", sid, mean, st);
        return;
      end
      want = due_q.pop_front();
      if (sid !== want.sensor) begin
        failures++;
        $error("result_sensor: expected %0d, actual %0d", want.sensor, sid);
      end
      if (mean !== want.mean) begin
        failures++;
        $error("filtered_value: expected %0d, actual %0d", want.mean, mean);
      end
      if (st !== want.state) begin
        failures++;
        $error("line_state: expected %0d, actual %0d", want.state, st);
      end
    endfunction
  endclass

  line_result_tracker sb;

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs on a handshake.
  initial begin
    #(TIMEOUT_NS);
    $display("trimmed_mean_line_sensor_classifier verification failed");
    $finish;
  end

  // Result monitor: a transfer happens on any edge with valid and ready high.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result(result_sensor, filtered_value, line_state);
  end

  // Receiver backpressure: runs of always-ready, coin flips, sparse ready,
  // and long stalls that can outlast a window completion.
  initial begin
    int pick;
    int span;
    forever begin
      pick = $urandom_range(0, 3);
      span = $urandom_range(20, 150);
      for (int k = 0; k < span; k++) begin
        @(posedge clk);
        case (pick)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          2:       out_ready <= ($urandom_range(0, 5) == 0);
          default: out_ready <= (k == span - 1);
        endcase
      end
    end
  end

  // Present one item and hold it until the transfer; called at a clock edge.
  task automatic push_item(action_t a, logic [IDX_W-1:0] s, logic [DATA_W-1:0] v);
    in_valid     <= 1'b1;
    action       <= a;
    sensor_index <= s;
    sample_value <= v;
    do @(posedge clk); while (!in_ready);
    sb.note_input(a, s, v);
  endtask

  // Writes every register, then an out-of-range index that must be ignored.
  // Write enable stays high across the sequence so it only toggles twice.
  task automatic load_regs(bit direct, logic [DATA_W-1:0] bofs, logic [DATA_W-1:0] wofs);
    logic [DATA_W-1:0] mode_word;
    logic [DATA_W-1:0] junk;
    mode_word    = DATA_W'($urandom);
    mode_word[0] = direct;
    junk         = DATA_W'($urandom);
    cfg_we    <= 1'b1;
    cfg_index <= REG_MODE;
    cfg_data  <= mode_word;
    @(posedge clk);
    sb.set_reg(REG_MODE, mode_word);
    cfg_index <= REG_BLACK_OFS;
    cfg_data  <= bofs;
    @(posedge clk);
    sb.set_reg(REG_BLACK_OFS, bofs);
    cfg_index <= REG_WHITE_OFS;
    cfg_data  <= wofs;
    @(posedge clk);
    sb.set_reg(REG_WHITE_OFS, wofs);
    cfg_index <= REG_NONE;
    cfg_data  <= junk;
    @(posedge clk);
    sb.set_reg(REG_NONE, junk);
    cfg_we <= 1'b0;
  endtask

  // Drain, then give the block time to finish any item that owes no result.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly samples; thresholds at extremes, equal to the partner threshold,
  // or random; samples often near the midpoint so classification varies.
  task automatic pick_item(output action_t a, output logic [IDX_W-1:0] s,
                           output logic [DATA_W-1:0] v);
    int r;
    int q;
    int sn;
    int mid;
    int t;
    r  = $urandom_range(0, 99);
    q  = $urandom_range(0, 9);
    s  = IDX_W'($urandom_range(0, NSENS - 1));
    sn = int'(s);
    v  = DATA_W'($urandom);
    if (r < 4) a = ACT_UNUSED;
    else if (r < 11) a = ACT_BLACK;
    else if (r < 18) a = ACT_WHITE;
    else a = ACT_SAMPLE;
    if (a == ACT_BLACK || a == ACT_WHITE) begin
      if (q == 0) v = '0;
      else if (q == 1) v = MAXV;
      else if (q == 2)
        v = DATA_W'((a == ACT_BLACK) ? sb.white_thr[sn] : sb.black_thr[sn]);
    end else if (a == ACT_SAMPLE) begin
      if (q < 2) begin
        v = (q == 0) ? '0 : MAXV;
      end else if (q < 6) begin
        mid = (sb.black_thr[sn] + sb.white_thr[sn]) >> 1;
        t   = mid + int'($urandom_range(0, 256)) - 128;
        v   = DATA_W'((t < 0) ? 0 : (t > 4095) ? 4095 : t);
      end
    end
  endtask

  // Bursts of back-to-back transfers separated by gaps of varied length.
  // With hold_off set, the sender stops halfway until nothing is owed.
  task automatic run_items(int count, bit hold_off);
    action_t           a;
    logic [IDX_W-1:0]  s;
    logic [DATA_W-1:0] v;
    int                sent;
    int                burst;
    int                gap;
    int                g;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 12);
      for (int k = 0; k < burst && sent < count; k++) begin
        pick_item(a, s, v);
        push_item(a, s, v);
        sent++;
        if (hold_off && sent == count / 2) begin
          in_valid <= 1'b0;
          do @(posedge clk); while (sb.pending() != 0);
        end
      end
      g = $urandom_range(0, 9);
      if (g < 3) gap = 0;
      else if (g < 9) gap = $urandom_range(1, 10);
      else gap = $urandom_range(20, 200);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed part, reset settings (midpoint mode, zero offsets).
    // Sensor 0: black high, white low, so polarity is black-high.
    push_item(ACT_BLACK, 3'd0, MAXV);
    push_item(ACT_WHITE, 3'd0, 12'd0);
    // Unused action code: ignored, no result.
    push_item(ACT_UNUSED, 3'd5, MAXV);
    // Sensor 7: thresholds stay equal, polarity stays undefined.
    push_item(ACT_BLACK, 3'd7, 12'd0);
    // Sensor 1: white high.
    push_item(ACT_WHITE, 3'd1, MAXV);
    for (int i = 0; i < WIN; i++) push_item(ACT_SAMPLE, 3'd7, MAXV);
    push_item(ACT_SAMPLE, 3'd0, 12'd0);
    push_item(ACT_SAMPLE, 3'd0, MAXV);
    push_item(ACT_SAMPLE, 3'd0, 12'd0);
    push_item(ACT_SAMPLE, 3'd0, MAXV);
    push_item(ACT_SAMPLE, 3'd0, 12'd1);
    push_item(ACT_SAMPLE, 3'd0, 12'd2);
    push_item(ACT_SAMPLE, 3'd0, 12'd4094);
    push_item(ACT_SAMPLE, 3'd0, 12'd2048);

    // Random phases, each under its own register setting; extremes first.
    for (int p = 0; p < MAX_PHASES; p++) begin
      settle();
      case (p)
        0:       load_regs(1'b0, 12'd0, 12'd0);
        1:       load_regs(1'b1, MAXV, MAXV);
        2:       load_regs(1'b0, MAXV, MAXV);
        3:       load_regs(1'b1, 12'd0, 12'd0);
        4:       load_regs(1'b0, 12'd0, MAXV);
        default: load_regs(1'($urandom_range(0, 1)), DATA_W'($urandom_range(0, 600)),
                           DATA_W'($urandom_range(0, 600)));
      endcase
      run_items(PHASE_ITEMS, p == 1);
    end

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.failures == 0)
      $display("trimmed_mean_line_sensor_classifier verification clean");
    else
      $display("trimmed_mean_line_sensor_classifier verification failed");
    $finish;
  end

endmodule
